[hw/rtl/mss_pkg.sv]
// Package: constants, types and helpers for the marching squares segment block.
package mss_pkg;
  localparam int MaxWidth     = 128;
  localparam int MaxHeight    = 128;
  localparam int FractionBits = 16;
  localparam int SampleW      = 24;
  localparam int EdgeW        = 15;
  localparam int CoordW       = 23;
  localparam int ColW         = $clog2(MaxWidth + 1);
  localparam int RowW         = $clog2(MaxHeight + 1);
  localparam int AddrW        = $clog2(MaxWidth);
  localparam int DiffW        = SampleW + 1;
  localparam int TW           = FractionBits + 1;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegLevel  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_SETUP, ST_DIV, ST_EMIT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DiffW-1:0] num;
    logic [DiffW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [TW-1:0] t;
  } div_rsp_t;
endpackage

[hw/rtl/mss_line_ram.sv]
// Line buffer: one-port synchronous RAM holding the previous row.
module mss_line_ram (
  input  logic                              clk,
  input  logic                              we,
  input  logic [mss_pkg::AddrW-1:0]         addr,
  input  logic signed [mss_pkg::SampleW-1:0] wdata,
  output logic signed [mss_pkg::SampleW-1:0] rdata
);
  logic signed [mss_pkg::SampleW-1:0] mem [mss_pkg::MaxWidth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[hw/rtl/mss_div.sv]
// Restoring divider: fraction t = num/den, one quotient bit per cycle.
module mss_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mss_pkg::div_req_t req,
  output mss_pkg::div_rsp_t rsp
);
  localparam int CntW = $clog2(mss_pkg::TW + 1);
  logic [mss_pkg::DiffW:0]   rem_r, rem_nxt;
  logic [mss_pkg::DiffW-1:0] den_r, den_nxt;
  logic [mss_pkg::TW-1:0]    q_r, q_nxt;
  logic [CntW-1:0]           cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [mss_pkg::DiffW:0]   trial;

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[mss_pkg::DiffW-1:0], 1'b0} - {1'b0, den_r};
    if (req.start) begin
      rem_nxt  = {1'b0, req.num};
      den_nxt  = req.den;
      q_nxt    = '0;
      cnt_nxt  = CntW'(mss_pkg::FractionBits);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[mss_pkg::DiffW]) begin
        rem_nxt = trial;
        q_nxt   = {q_r[mss_pkg::TW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[mss_pkg::DiffW-1:0], 1'b0};
        q_nxt   = {q_r[mss_pkg::TW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.t    = q_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without busy");
  a_q_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> q_r <= mss_pkg::TW'(1 << mss_pkg::FractionBits))
    else $error("quotient above one");
  a_no_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("done while busy");
endmodule

[hw/rtl/marching_squares_segments_top.sv]
// Top level: marching squares isoline segment generator.
// Height samples enter on in_valid/in_stall in raster order, south row first,
// west to east; each sample is one transfer. The previous row lives in a
// one-port line RAM. A sample at column > 0 and row > 0 completes a cell and
// yields zero, one or two segments on out_valid/out_stall, one per transfer.
// Per sample: the sample is taken, the RAM is read, a setup step follows, then
// four crossing slots, each resolved directly or, when the crossing lies strictly
// inside the edge, through the shared serial divider (up to four do), then each
// segment is held on the outputs until it is transferred. A sample with no cell
// or no crossing returns to idle after the setup, skipping slots and output.
// A new sample is taken only after the previous one is fully delivered.
// While the receiver stalls, the output register and all fields hold.
// Reset (synchronous, rst_n low) sets width and height to 128, level to 0
// and the position to column 0, row 0; the line RAM holds garbage until row 0
// writes it. Writing width or height returns the position to the origin. cfg_we,
// cfg_index and cfg_data write a register; write only when idle (not enforced).
module marching_squares_segments_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [23:0]                        cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [mss_pkg::SampleW-1:0] in_height_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mss_pkg::EdgeW-1:0]          out_first_edge,
  output logic [mss_pkg::CoordW-1:0]         out_first_x,
  output logic [mss_pkg::CoordW-1:0]         out_first_y,
  output logic [mss_pkg::EdgeW-1:0]          out_second_edge,
  output logic [mss_pkg::CoordW-1:0]         out_second_x,
  output logic [mss_pkg::CoordW-1:0]         out_second_y,
  output logic                               out_last_of_cell
);
  localparam int SW = mss_pkg::SampleW;
  localparam int DW = mss_pkg::DiffW;
  localparam int TW = mss_pkg::TW;
  localparam int CW = mss_pkg::ColW;
  localparam int RW = mss_pkg::RowW;
  localparam int FB = mss_pkg::FractionBits;

  mss_pkg::state_t state_r, state_nxt;

  logic [7:0]          width_r, height_r;
  logic signed [SW-1:0] level_r;
  logic [CW-1:0]       col_r, col_nxt;
  logic [RW-1:0]       row_r, row_nxt;
  logic [CW-1:0]       w_eff, col_cur;
  logic [RW-1:0]       h_eff, row_cur;
  logic signed [SW-1:0] s_r, left_r, aleft_r;
  logic [CW-1:0]       cx_r;
  logic [RW-1:0]       cy_r;
  logic                cell_r;
  logic [3:0]          idx_r;
  logic [TW-1:0]       tb_r, tt_r, tl_r, tr_r;
  logic [1:0]          dsel_r;
  logic                dpend_r;
  logic                seg_r;
  logic signed [SW-1:0] above;

  logic ram_we;
  logic in_fire, out_fire;
  mss_pkg::div_req_t dreq;
  mss_pkg::div_rsp_t drsp;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign in_stall = (state_r != mss_pkg::ST_IDLE);

  always_comb begin
    if (width_r < 8'd2) w_eff = CW'(2);
    else if (32'(width_r) > mss_pkg::MaxWidth) w_eff = CW'(mss_pkg::MaxWidth);
    else w_eff = CW'(width_r);
    if (height_r < 8'd2) h_eff = RW'(2);
    else if (32'(height_r) > mss_pkg::MaxHeight) h_eff = RW'(mss_pkg::MaxHeight);
    else h_eff = RW'(height_r);
    col_cur = (col_r >= w_eff) ? '0 : col_r;
    row_cur = (row_r >= h_eff) ? '0 : row_r;
  end

  assign ram_we = in_fire;
  mss_line_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (col_cur[mss_pkg::AddrW-1:0]),
    .wdata (in_height_sample),
    .rdata (above)
  );

  logic signed [SW-1:0] a00_r;
  logic signed [SW-1:0] a10_r;

  // crossing operands for divider slot: 0 bottom, 1 top, 2 left, 3 right
  logic signed [SW-1:0] va, vb;
  logic signed [DW-1:0] num, den;
  logic [DW-1:0]        unum, uden;
  logic [TW-1:0]        t_fast;
  logic                 need_div;
  always_comb begin
    unique case (dsel_r)
      2'd0: begin va = a00_r;  vb = a10_r; end
      2'd1: begin va = left_r; vb = s_r;   end
      2'd2: begin va = a00_r;  vb = left_r; end
      default: begin va = a10_r; vb = s_r; end
    endcase
    num = DW'(level_r) - DW'(va);
    den = DW'(vb) - DW'(va);
    if (den[DW-1]) begin
      unum = DW'(-num);
      uden = DW'(-den);
    end else begin
      unum = num;
      uden = den;
    end
    need_div = 1'b0;
    if (den == '0) t_fast = TW'(1 << (FB - 1));
    else if ($signed(unum) <= 0) t_fast = '0;
    else if (unum >= uden) t_fast = TW'(1 << FB);
    else begin
      t_fast   = '0;
      need_div = 1'b1;
    end
  end

  assign dreq.start = (state_r == mss_pkg::ST_DIV) && !dpend_r && need_div;
  assign dreq.num   = unum;
  assign dreq.den   = uden;

  mss_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic slot_done;
  logic [TW-1:0] slot_t;
  always_comb begin
    slot_done = 1'b0;
    slot_t    = t_fast;
    if (state_r == mss_pkg::ST_DIV) begin
      if (!dpend_r && !need_div) slot_done = 1'b1;
      if (dpend_r && drsp.done) begin
        slot_done = 1'b1;
        slot_t    = drsp.t;
      end
    end
  end

  logic two_seg;
  assign two_seg = (idx_r == 4'd5) || (idx_r == 4'd10);

  logic [3:0] idx_c;
  always_comb begin
    idx_c[0] = (a00_r >= level_r);
    idx_c[1] = (a10_r >= level_r);
    idx_c[2] = (s_r >= level_r);
    idx_c[3] = (left_r >= level_r);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mss_pkg::ST_IDLE:  if (in_fire) state_nxt = mss_pkg::ST_READ;
      mss_pkg::ST_READ:  state_nxt = mss_pkg::ST_SETUP;
      mss_pkg::ST_SETUP: begin
        if (!cell_r || idx_c == 4'd0 || idx_c == 4'd15) state_nxt = mss_pkg::ST_IDLE;
        else state_nxt = mss_pkg::ST_DIV;
      end
      mss_pkg::ST_DIV:   if (slot_done && dsel_r == 2'd3) state_nxt = mss_pkg::ST_EMIT;
      mss_pkg::ST_EMIT:  if (out_fire && (seg_r || !two_seg)) state_nxt = mss_pkg::ST_IDLE;
      default:           state_nxt = mss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    col_nxt = col_cur + 1'b1;
    row_nxt = row_cur;
    if (col_nxt >= w_eff) begin
      col_nxt = '0;
      row_nxt = row_cur + 1'b1;
      if (row_nxt >= h_eff) row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mss_pkg::ST_IDLE;
      width_r  <= 8'd128;
      height_r <= 8'd128;
      level_r  <= '0;
      col_r    <= '0;
      row_r    <= '0;
      dpend_r  <= 1'b0;
      seg_r    <= 1'b0;
      dsel_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          mss_pkg::RegWidth: begin
            width_r <= cfg_data[7:0]; col_r <= '0; row_r <= '0;
          end
          mss_pkg::RegHeight: begin
            height_r <= cfg_data[7:0]; col_r <= '0; row_r <= '0;
          end
          mss_pkg::RegLevel: level_r <= cfg_data;
          default: ;
        endcase
      end else if (in_fire) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (state_r == mss_pkg::ST_SETUP) begin
        dsel_r  <= '0;
        dpend_r <= 1'b0;
        seg_r   <= 1'b0;
      end
      if (state_r == mss_pkg::ST_DIV) begin
        if (dreq.start) dpend_r <= 1'b1;
        if (slot_done) begin
          dpend_r <= 1'b0;
          dsel_r  <= dsel_r + 1'b1;
        end
      end
      if (state_r == mss_pkg::ST_EMIT && out_fire) seg_r <= 1'b1;
    end
    if (in_fire) begin
      s_r    <= in_height_sample;
      left_r <= s_r;
      cell_r <= (col_cur != '0) && (row_cur != '0);
      cx_r   <= col_cur - 1'b1;
      cy_r   <= row_cur - 1'b1;
      a10_r  <= a10_r;
    end
    if (state_r == mss_pkg::ST_READ) begin
      a00_r   <= aleft_r;
      a10_r   <= above;
      aleft_r <= above;
    end
    if (state_r == mss_pkg::ST_SETUP) idx_r <= idx_c;
    if (slot_done) begin
      case (dsel_r)
        2'd0: tb_r <= slot_t;
        2'd1: tt_r <= slot_t;
        2'd2: tl_r <= slot_t;
        default: tr_r <= slot_t;
      endcase
    end
  end

  // left_r must be the previous sample, s_r is current: fix ordering at accept
  // (left_r takes the old s_r on the same edge s_r takes the new sample).

  // endpoint assembly
  localparam int CoordWL = 40;
  localparam int EW = CW + RW + 2;
  logic [CoordWL-1:0] xf, yf, one;
  logic [EW-1:0] node, eb, et, el, er;
  logic [CoordWL-1:0] pbx, pby, ptx, pty, plx, ply, prx, pry;
  always_comb begin
    xf   = CoordWL'(cx_r) << FB;
    yf   = CoordWL'(cy_r) << FB;
    one  = CoordWL'(1) << FB;
    node = EW'(cy_r) * EW'(w_eff) + EW'(cx_r);
    eb   = node << 1;
    et   = (node + EW'(w_eff)) << 1;
    el   = (node << 1) + EW'(1);
    er   = ((node + EW'(1)) << 1) + EW'(1);
    pbx = xf + CoordWL'(tb_r); pby = yf;
    ptx = xf + CoordWL'(tt_r); pty = yf + one;
    plx = xf;                  ply = yf + CoordWL'(tl_r);
    prx = xf + one;            pry = yf + CoordWL'(tr_r);
  end

  always_comb begin
    out_first_edge  = '0; out_first_x  = '0; out_first_y  = '0;
    out_second_edge = '0; out_second_x = '0; out_second_y = '0;
    case (idx_r)
      4'd1, 4'd14: begin
        out_first_edge = el[14:0]; out_first_x = plx[22:0]; out_first_y = ply[22:0];
        out_second_edge = eb[14:0]; out_second_x = pbx[22:0]; out_second_y = pby[22:0];
      end
      4'd2, 4'd13: begin
        out_first_edge = eb[14:0]; out_first_x = pbx[22:0]; out_first_y = pby[22:0];
        out_second_edge = er[14:0]; out_second_x = prx[22:0]; out_second_y = pry[22:0];
      end
      4'd3, 4'd12: begin
        out_first_edge = el[14:0]; out_first_x = plx[22:0]; out_first_y = ply[22:0];
        out_second_edge = er[14:0]; out_second_x = prx[22:0]; out_second_y = pry[22:0];
      end
      4'd4, 4'd11: begin
        out_first_edge = er[14:0]; out_first_x = prx[22:0]; out_first_y = pry[22:0];
        out_second_edge = et[14:0]; out_second_x = ptx[22:0]; out_second_y = pty[22:0];
      end
      4'd6, 4'd9: begin
        out_first_edge = eb[14:0]; out_first_x = pbx[22:0]; out_first_y = pby[22:0];
        out_second_edge = et[14:0]; out_second_x = ptx[22:0]; out_second_y = pty[22:0];
      end
      4'd7, 4'd8: begin
        out_first_edge = el[14:0]; out_first_x = plx[22:0]; out_first_y = ply[22:0];
        out_second_edge = et[14:0]; out_second_x = ptx[22:0]; out_second_y = pty[22:0];
      end
      4'd5: begin
        if (!seg_r) begin
          out_first_edge = el[14:0]; out_first_x = plx[22:0]; out_first_y = ply[22:0];
          out_second_edge = et[14:0]; out_second_x = ptx[22:0]; out_second_y = pty[22:0];
        end else begin
          out_first_edge = eb[14:0]; out_first_x = pbx[22:0]; out_first_y = pby[22:0];
          out_second_edge = er[14:0]; out_second_x = prx[22:0]; out_second_y = pry[22:0];
        end
      end
      4'd10: begin
        if (!seg_r) begin
          out_first_edge = el[14:0]; out_first_x = plx[22:0]; out_first_y = ply[22:0];
          out_second_edge = eb[14:0]; out_second_x = pbx[22:0]; out_second_y = pby[22:0];
        end else begin
          out_first_edge = er[14:0]; out_first_x = prx[22:0]; out_first_y = pry[22:0];
          out_second_edge = et[14:0]; out_second_x = ptx[22:0]; out_second_y = pty[22:0];
        end
      end
      default: ;
    endcase
  end

  assign out_valid        = (state_r == mss_pkg::ST_EMIT);
  assign out_last_of_cell = !two_seg || seg_r;

  a_no_in_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> state_r == mss_pkg::ST_IDLE) else $error("accept while busy");
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> idx_r != 4'd0 && idx_r != 4'd15) else $error("emit for empty case");
  a_second_only_saddle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && seg_r) |-> two_seg) else $error("second segment without saddle");
endmodule

[tb/testbench.sv]
// Testbench for the marching squares segment block: scoreboard against a local predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EdgeW        = mss_pkg::EdgeW;
  localparam int CoordW       = mss_pkg::CoordW;
  localparam int SampleW      = mss_pkg::SampleW;
  localparam int MaxWidth     = mss_pkg::MaxWidth;
  localparam int FractionBits = mss_pkg::FractionBits;

  typedef struct packed {
    logic [EdgeW-1:0]  e0;
    logic [CoordW-1:0] x0;
    logic [CoordW-1:0] y0;
    logic [EdgeW-1:0]  e1;
    logic [CoordW-1:0] x1;
    logic [CoordW-1:0] y1;
    logic              last;
  } segment_t;

  typedef struct {
    logic [EdgeW-1:0]  edge_id;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } crossing_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = mss_pkg::RegWidth;
  logic [23:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SampleW-1:0] in_height_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [EdgeW-1:0] out_first_edge, out_second_edge;
  logic [CoordW-1:0] out_first_x, out_first_y, out_second_x, out_second_y;
  logic out_last_of_cell;

  marching_squares_segments_top u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  int unsigned pw = 128, ph = 128;
  int signed plevel = 0;
  int signed prow_buf [MaxWidth];
  int signed pleft, pabove_left;
  int unsigned pcol, prow;

  segment_t expected_segments[$];
  int errors = 0, mismatches = 0, segments_seen = 0, samples_sent = 0;
  int unsigned cycle_count = 0;
  bit idle_enable = 1'b1;
  int unsigned case_hits[16];

  function automatic int unsigned clamp_dim(int unsigned v);
    if (v < 2) return 2;
    if (v > 128) return 128;
    return v;
  endfunction

  function automatic longint crossing_frac(int signed va, int signed vb, int signed lv);
    longint num, den;
    num = longint'(lv) - va;
    den = longint'(vb) - va;
    if (den == 0) return 64'd1 << (FractionBits - 1);
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num <= 0) return 0;
    if (num >= den) return 64'd1 << FractionBits;
    return (num << FractionBits) / den;
  endfunction

  function automatic crossing_t mk(int unsigned ex, int unsigned ey, int unsigned w,
                                   bit vert, longint px, longint py);
    crossing_t c;
    c.edge_id = EdgeW'((ey * w + ex) * 2 + vert);
    c.x = CoordW'(px);
    c.y = CoordW'(py);
    return c;
  endfunction

  function automatic segment_t seg(crossing_t a, crossing_t b, bit last);
    segment_t s;
    s = '{a.edge_id, a.x, a.y, b.edge_id, b.x, b.y, last};
    return s;
  endfunction

  function automatic void add_expected(segment_t s);
    expected_segments.insert(expected_segments.size(), s);
  endfunction

  task automatic predict_sample(int signed smp);
    int unsigned w, h, col, row, x, y;
    int signed above, v00, v10, v01, v11;
    int unsigned idx;
    longint xf, yf, one;
    crossing_t pb, pt, pl, pr;
    w = clamp_dim(pw);
    h = clamp_dim(ph);
    col = (pcol >= w) ? 0 : pcol;
    row = (prow >= h) ? 0 : prow;
    above = prow_buf[col % MaxWidth];
    if (col > 0 && row > 0) begin
      x = col - 1;
      y = row - 1;
      v00 = pabove_left; v10 = above; v01 = pleft; v11 = smp;
      idx = 0;
      if (v00 >= plevel) idx |= 1;
      if (v10 >= plevel) idx |= 2;
      if (v11 >= plevel) idx |= 4;
      if (v01 >= plevel) idx |= 8;
      case_hits[idx]++;
      xf = longint'(x) << FractionBits;
      yf = longint'(y) << FractionBits;
      one = 64'd1 << FractionBits;
      pb = mk(x, y, w, 0, xf + crossing_frac(v00, v10, plevel), yf);
      pt = mk(x, y + 1, w, 0, xf + crossing_frac(v01, v11, plevel), yf + one);
      pl = mk(x, y, w, 1, xf, yf + crossing_frac(v00, v01, plevel));
      pr = mk(x + 1, y, w, 1, xf + one, yf + crossing_frac(v10, v11, plevel));
      case (idx)
        1, 14: add_expected(seg(pl, pb, 1));
        2, 13: add_expected(seg(pb, pr, 1));
        3, 12: add_expected(seg(pl, pr, 1));
        4, 11: add_expected(seg(pr, pt, 1));
        6, 9:  add_expected(seg(pb, pt, 1));
        7, 8:  add_expected(seg(pl, pt, 1));
        5: begin
          add_expected(seg(pl, pt, 0));
          add_expected(seg(pb, pr, 1));
        end
        10: begin
          add_expected(seg(pl, pb, 0));
          add_expected(seg(pr, pt, 1));
        end
        default: ;
      endcase
    end
    prow_buf[col % MaxWidth] = smp;
    pabove_left = above;
    pleft = smp;
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
    pcol = col;
    prow = row;
  endtask

  // valid stays high after a transfer until the next item or an idle drops it
  task automatic send_sample(int signed smp);
    if (idle_enable && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (idle_enable && $urandom_range(99) < 37) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_height_sample <= SampleW'(smp);
    predict_sample(smp);
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  task automatic drain();
    int unsigned guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_segments.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[23:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == mss_pkg::RegWidth) begin
      pw = val & 8'hFF; pcol = 0; prow = 0;
    end else if (idx == mss_pkg::RegHeight) begin
      ph = val & 8'hFF; pcol = 0; prow = 0;
    end else begin
      plevel = int'(signed'(val[23:0]));
    end
  endtask

  // Fill a grid with values from a small set around the level, plus extremes and random values over the full range.
  task automatic send_grid(int unsigned rows, int unsigned spread);
    int unsigned w;
    int signed v;
    w = clamp_dim(pw);
    for (int unsigned i = 0; i < rows * w; i++) begin
      case ($urandom_range(9))
        0: v = -8388608;
        1: v = 8388607;
        2: v = plevel;
        3: v = int'($urandom) >>> 8;
        default: v = plevel + int'($urandom_range(2 * spread)) - int'(spread);
      endcase
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      send_sample(v);
    end
  endtask

  task automatic test_directed_saddles();
    int signed pat [8];
    pat = '{10, -10, 10, -10, -10, 10, -10, 10};
    write_reg(mss_pkg::RegWidth, 4);
    write_reg(mss_pkg::RegHeight, 2);
    write_reg(mss_pkg::RegLevel, 0);
    foreach (pat[i]) send_sample(pat[i]);
    write_reg(mss_pkg::RegWidth, 2);
    send_sample(5); send_sample(5); send_sample(5); send_sample(-8388608);
    send_sample(8388607); send_sample(-8388608); send_sample(-8388608); send_sample(8388607);
    send_sample(0); send_sample(0); send_sample(0); send_sample(-1);
  endtask

  task automatic test_extreme_levels();
    write_reg(mss_pkg::RegWidth, 3);
    write_reg(mss_pkg::RegHeight, 3);
    write_reg(mss_pkg::RegLevel, 24'h800000);
    send_grid(3, 4);
    write_reg(mss_pkg::RegLevel, 24'h7FFFFF);
    send_grid(3, 4);
  endtask

  task automatic test_size_clamps();
    write_reg(mss_pkg::RegLevel, 100);
    write_reg(mss_pkg::RegWidth, 0);
    write_reg(mss_pkg::RegHeight, 1);
    send_grid(5, 200);
    write_reg(mss_pkg::RegWidth, 255);
    write_reg(mss_pkg::RegHeight, 255);
    send_grid(2, 200);
  endtask

  task automatic test_random_grids();
    while (samples_sent < 400) begin
      write_reg(mss_pkg::RegWidth, $urandom_range(2, 9));
      write_reg(mss_pkg::RegHeight, $urandom_range(2, 6));
      write_reg(mss_pkg::RegLevel, ($urandom_range(3) == 0) ? $urandom : $urandom_range(400));
      idle_enable = ($urandom_range(4) != 0);
      send_grid($urandom_range(2, 8), $urandom_range(1, 300));
    end
    idle_enable = 1'b1;
  endtask

  task automatic test_pause_until_empty();
    write_reg(mss_pkg::RegWidth, 5);
    write_reg(mss_pkg::RegHeight, 4);
    send_grid(2, 50);
    in_valid <= 1'b0;
    while (expected_segments.size() != 0) @(posedge clk);
    send_grid(3, 50);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_stall <= idle_enable ? ($urandom_range(99) < 37) : 1'b0;
    if (rst_n && out_valid && !out_stall) begin
      segment_t got, want;
      got = '{out_first_edge, out_first_x, out_first_y, out_second_edge,
              out_second_x, out_second_y, out_last_of_cell};
      segments_seen++;
      if (expected_segments.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected segment %p", got);
      end else begin
        want = expected_segments.pop_front();
        if (got !== want) begin
          errors++;
          if (mismatches++ < 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_saddles();
    test_extreme_levels();
    test_size_clamps();
    test_pause_until_empty();
    test_random_grids();
    drain();
    if (expected_segments.size() != 0) errors++;
    $display("sent %0d samples, checked %0d segments, saddles %0d/%0d",
             samples_sent, segments_seen, case_hits[5], case_hits[10]);
    if (errors == 0) $display("marching_squares_segments_top verification clean");
    else $display("marching_squares_segments_top verification failed");
    $finish;
  end

  initial begin
    wait (cycle_count >= 900000);
    $display("marching_squares_segments_top verification failed");
    $finish;
  end
endmodule
